>>> rtl/cfr_pkg.sv
// Shared types and constants of the CAN fragment reassembler.
// Item structs, controller/datapath command and status, result codes.
// No dependencies.
`default_nettype none

package cfr_pkg;

    // Sizing
    localparam int NUM_SLOTS     = 4;
    localparam int MAX_MSG_BYTES = 256;
    localparam int FRAME_BYTES   = 8;
    localparam int MAX_RESULTS   = 32;
    localparam int NUM_CFG       = 4;

    // Field widths fixed by the item formats
    localparam int SLOT_W  = 2;
    localparam int IDENT_W = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int ID_W    = 16;
    localparam int FRAG_W  = 7;
    localparam int SIZE_W  = 9;
    localparam int EV_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int LANE_W     = $clog2(FRAME_BYTES);
    localparam int POS_W      = $clog2(MAX_MSG_BYTES + 1);
    localparam int ROWF_W     = POS_W - LANE_W;
    localparam int ROW_W      = $clog2(MAX_MSG_BYTES / FRAME_BYTES);
    localparam int BANK_AW    = SLOT_W + ROW_W;
    localparam int BANK_DEPTH = NUM_SLOTS * MAX_MSG_BYTES / FRAME_BYTES;
    localparam int WCNT_W     = $clog2(MAX_RESULTS);
    localparam int NW_W       = WCNT_W + 1;

    // Register reset value
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    // Opcodes
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result event codes
    localparam logic [EV_W-1:0] EV_IGNORED  = 3'd0;
    localparam logic [EV_W-1:0] EV_RESEQ    = 3'd1;
    localparam logic [EV_W-1:0] EV_STORED   = 3'd2;
    localparam logic [EV_W-1:0] EV_COMPLETE = 3'd3;
    localparam logic [EV_W-1:0] EV_DROPPED  = 3'd4;
    localparam logic [EV_W-1:0] EV_RELEASED = 3'd5;

    typedef struct packed {
        logic               opcode;
        logic [SLOT_W-1:0]  slot;
        logic [IDENT_W-1:0] frame_ident;
        logic [LEN_W-1:0]   frame_len;
        logic [DATA_W-1:0]  frame_payload;
    } in_item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [SLOT_W-1:0] out_slot;
        logic [ID_W-1:0]   message_id;
        logic [DATA_W-1:0] data_word;
        logic [LEN_W-1:0]  word_bytes;
        logic              last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic eval;
        logic emit_word;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic multi;
        logic last_word;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/cfr_ctrl.sv
// Sequencer of the CAN fragment reassembler: accept, evaluate, word readout.
// Depends on cfr_pkg.
`default_nettype none

module cfr_ctrl
    import cfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    frame_valid,
    output logic         frame_stall,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take one item at a time
    assign frame_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.out_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = sts.multi ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = sts.last_word ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cfr_datapath.sv
// Datapath of the CAN fragment reassembler: size registers, slot state,
// byte-lane message banks and the result register. Depends on cfr_pkg.
`default_nettype none

module cfr_datapath
    import cfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire in_item_t             frame,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    input  wire logic                 result_stall,
    output logic                      result_valid,
    output out_item_t                 result
);

    typedef enum logic [1:0] {
        ST_READY,
        ST_ONAIR,
        ST_BUSY
    } slot_st_t;

    in_item_t          in_reg;
    logic [SIZE_W-1:0] size_reg   [NUM_CFG];
    slot_st_t          status_reg [NUM_SLOTS];
    logic [ID_W-1:0]   msg_id_reg [NUM_SLOTS];
    logic [FRAG_W-1:0] frags_reg  [NUM_SLOTS];
    logic [POS_W-1:0]  wp_reg     [NUM_SLOTS];
    logic [WCNT_W-1:0] word_cnt_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    // Message banks, one per byte lane
    logic [7:0]        bank_mem    [FRAME_BYTES][BANK_DEPTH];
    logic [7:0]        rd_data_reg [FRAME_BYTES];

    logic [SLOT_W-1:0] s;
    logic              is_ready;
    logic              is_busy;
    logic [ID_W-1:0]   id_in;
    logic [FRAG_W-1:0] frag_in;
    logic [15:0]       raw_sz;
    logic [POS_W-1:0]  sz;
    logic [FRAG_W-1:0] frags_init;
    logic [ID_W-1:0]   eff_id;
    logic [FRAG_W-1:0] eff_frags;
    logic [POS_W-1:0]  eff_wp;
    logic              src_ok;
    logic              frag_ok;
    logic [LEN_W-1:0]  len8;
    logic [POS_W-1:0]  room;
    logic [LEN_W-1:0]  n_store;
    logic [POS_W-1:0]  new_wp;
    logic              store;
    logic [POS_W:0]    nw_new_full;
    logic [EV_W-1:0]   eval_ev;
    logic [ID_W-1:0]   eval_id;

    logic [LANE_W-1:0]  lane_off [FRAME_BYTES];
    logic [ROWF_W-1:0]  lane_row [FRAME_BYTES];
    logic               we       [FRAME_BYTES];
    logic [BANK_AW-1:0] waddr    [FRAME_BYTES];
    logic [7:0]         wdata    [FRAME_BYTES];
    logic [BANK_AW-1:0] raddr;

    logic [POS_W:0]    nw_cur_full;
    logic [NW_W-1:0]   nw_cur;
    logic [POS_W-1:0]  rem;
    logic [LEN_W-1:0]  wb;
    logic [DATA_W-1:0] word;

    assign s        = in_reg.slot;
    assign is_ready = (status_reg[s] == ST_READY);
    assign is_busy  = (status_reg[s] == ST_BUSY);
    assign id_in    = in_reg.frame_ident[FRAG_W +: ID_W];
    assign frag_in  = in_reg.frame_ident[FRAG_W-1:0];

    // Clamp the slot size and derive the fragment count of a fresh message
    always_comb
    begin
        raw_sz = 16'(size_reg[s]);
        if (raw_sz > 16'(MAX_MSG_BYTES))
        begin
            sz = POS_W'(MAX_MSG_BYTES);
        end
        else
        begin
            sz = POS_W'(raw_sz);
        end
        if (sz > POS_W'(FRAME_BYTES))
        begin
            frags_init = FRAG_W'((sz - POS_W'(1)) >> LANE_W);
        end
        else
        begin
            frags_init = '0;
        end
    end

    // Slot view after arming a ready slot
    assign eff_id    = is_ready ? id_in : msg_id_reg[s];
    assign eff_frags = is_ready ? frags_init : frags_reg[s];
    assign eff_wp    = is_ready ? '0 : wp_reg[s];
    assign src_ok    = (id_in[7:0] == eff_id[7:0]);
    assign frag_ok   = (frag_in == eff_frags);

    // Byte count to store: frame length capped at one frame, then at the room left
    always_comb
    begin
        if (in_reg.frame_len > LEN_W'(FRAME_BYTES))
        begin
            len8 = LEN_W'(FRAME_BYTES);
        end
        else
        begin
            len8 = in_reg.frame_len;
        end
        if (eff_wp < sz)
        begin
            room = sz - eff_wp;
        end
        else
        begin
            room = '0;
        end
        if (room < POS_W'(len8))
        begin
            n_store = LEN_W'(room);
        end
        else
        begin
            n_store = len8;
        end
    end

    assign new_wp      = eff_wp + POS_W'(n_store);
    assign store       = (in_reg.opcode == OP_FRAME) && !is_busy && src_ok && frag_ok;
    assign nw_new_full = ({1'b0, new_wp} + (POS_W+1)'(FRAME_BYTES - 1)) >> LANE_W;

    // Pick the single result of an item
    always_comb
    begin
        eval_id = eff_id;
        priority if (in_reg.opcode == OP_RELEASE)
        begin
            eval_ev = EV_RELEASED;
            eval_id = msg_id_reg[s];
        end
        else if (is_busy)
        begin
            eval_ev = EV_DROPPED;
        end
        else if (!src_ok)
        begin
            eval_ev = EV_IGNORED;
        end
        else if (!frag_ok)
        begin
            eval_ev = EV_RESEQ;
        end
        else if (eff_frags != '0)
        begin
            eval_ev = EV_STORED;
        end
        else
        begin
            eval_ev = EV_COMPLETE;
        end
    end

    // Steer frame bytes onto the lanes their buffer positions fall in
    always_comb
    begin
        for (int l = 0; l < FRAME_BYTES; l++)
        begin
            lane_off[l] = LANE_W'(l) - eff_wp[LANE_W-1:0];
            lane_row[l] = eff_wp[POS_W-1:LANE_W]
                        + ((LANE_W'(l) < eff_wp[LANE_W-1:0]) ? ROWF_W'(1) : ROWF_W'(0));
            we[l]    = cmd.eval && store && ({1'b0, lane_off[l]} < n_store);
            waddr[l] = {s, lane_row[l][ROW_W-1:0]};
            wdata[l] = in_reg.frame_payload[{lane_off[l], 3'b000} +: 8];
        end
    end

    assign raddr = {s, ROW_W'(word_cnt_reg)};

    // Word readout bookkeeping
    always_comb
    begin
        nw_cur_full = ({1'b0, wp_reg[s]} + (POS_W+1)'(FRAME_BYTES - 1)) >> LANE_W;
        if (nw_cur_full > (POS_W+1)'(MAX_RESULTS))
        begin
            nw_cur = NW_W'(MAX_RESULTS);
        end
        else
        begin
            nw_cur = NW_W'(nw_cur_full);
        end
        rem = wp_reg[s] - (POS_W'(word_cnt_reg) << LANE_W);
        if (rem >= POS_W'(FRAME_BYTES))
        begin
            wb = LEN_W'(FRAME_BYTES);
        end
        else
        begin
            wb = LEN_W'(rem);
        end
        for (int l = 0; l < FRAME_BYTES; l++)
        begin
            word[8*l +: 8] = (LEN_W'(l) < wb) ? rd_data_reg[l] : 8'h00;
        end
    end

    assign sts.out_free  = !out_valid_reg || !result_stall;
    assign sts.multi     = store && (eff_frags == '0) && (nw_new_full != '0);
    assign sts.last_word = ({1'b0, word_cnt_reg} + NW_W'(1)) == nw_cur;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= frame;
        end
    end

    // Write the banks and read one word row
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < FRAME_BYTES; l++)
        begin
            if (we[l])
            begin
                bank_mem[l][waddr[l]] <= wdata[l];
            end
            rd_data_reg[l] <= bank_mem[l][raddr];
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.eval && !sts.multi)
        begin
            out_reg.event_res  <= eval_ev;
            out_reg.out_slot   <= s;
            out_reg.message_id <= eval_id;
            out_reg.data_word  <= '0;
            out_reg.word_bytes <= '0;
            out_reg.last       <= 1'b1;
        end
        else if (cmd.emit_word)
        begin
            out_reg.event_res  <= EV_COMPLETE;
            out_reg.out_slot   <= s;
            out_reg.message_id <= msg_id_reg[s];
            out_reg.data_word  <= word;
            out_reg.word_bytes <= wb;
            out_reg.last       <= sts.last_word;
        end
    end

    // Control state: config, slot state, word counter, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                size_reg[i] <= SIZE_RESET;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_READY;
                msg_id_reg[i] <= '0;
                frags_reg[i]  <= '0;
                wp_reg[i]     <= '0;
            end
            word_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg[cfg_index] <= cfg_data;
            end

            // Advance the slot on an evaluated item
            if (cmd.eval)
            begin
                word_cnt_reg <= '0;
                if (in_reg.opcode == OP_RELEASE)
                begin
                    if (is_busy)
                    begin
                        status_reg[s] <= ST_READY;
                    end
                end
                else if (!is_busy)
                begin
                    if (is_ready)
                    begin
                        status_reg[s] <= ST_ONAIR;
                        msg_id_reg[s] <= id_in;
                        frags_reg[s]  <= frags_init;
                        wp_reg[s]     <= '0;
                    end
                    if (src_ok && !frag_ok)
                    begin
                        status_reg[s] <= ST_READY;
                    end
                    else if (src_ok)
                    begin
                        wp_reg[s] <= new_wp;
                        if (eff_frags != '0)
                        begin
                            frags_reg[s] <= eff_frags - FRAG_W'(1);
                        end
                        else
                        begin
                            status_reg[s] <= ST_BUSY;
                        end
                    end
                end
            end
            else if (cmd.emit_word && !sts.last_word)
            begin
                word_cnt_reg <= word_cnt_reg + WCNT_W'(1);
            end

            // Hold the result until taken
            if ((cmd.eval && !sts.multi) || cmd.emit_word)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/can_fragment_reassembler_unit.sv
// CAN fragment reassembler, one filter slot buffer per slot.
// Frame channel in (frame_valid/frame_stall/frame), result channel out
// (result_valid/result_stall/result), slot size writes on the cfg port.
// Each frame or release item is evaluated against its slot's state. Frames
// of a multi-frame message are appended to that slot's buffer; the last
// fragment turns the slot busy and reads the message out as 8-byte words,
// the final word marked last. Busy slots drop frames until released.
// Sequence: an item is taken into the input register and evaluated once the
// result register is free, which loads its result. A completion then reads
// the message out word by word, each word through the registered read of
// the eight byte-lane banks followed by the load of the result register.
// One item is in work at a time.
// A result waits in the output register while result_stall is high; the
// block stops evaluating until it is taken but still accepts one item.
// Reset: sizes return to 8, all slots ready, no result pending. The message
// banks are not cleared; only bytes written for the current message are read.
// The cfg port is always ready; write it only while the block is idle.
// Depends on cfr_pkg, cfr_ctrl, cfr_datapath.
`default_nettype none

module can_fragment_reassembler_unit
    import cfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 frame_valid,
    output logic                      frame_stall,
    input  wire in_item_t             frame,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output out_item_t                 result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    cfr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    cfr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("item accepted while another is in work");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval || cmd.emit_word |-> sts.out_free)
        else $error("result register loaded while occupied");

    // Only completion words carry data bytes
    a_data_complete: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.word_bytes != '0 |-> result.event_res == EV_COMPLETE)
        else $error("data bytes on a non-completion result");
`endif

endmodule

`default_nettype wire

>>> tb/can_fragment_reassembler_unit_tb.sv
// Self-checking testbench for can_fragment_reassembler_unit.
// Predicts per-slot reassembly in a scoreboard class and checks every result item.
// Depends on cfr_pkg and the reassembler RTL only.
`timescale 1ns / 100ps

module can_fragment_reassembler_unit_tb;
    import cfr_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 200;

    // Slot reassembly predictor and the queue of result items it expects
    class reassembly_scoreboard;
        typedef enum logic [1:0] {SLOT_READY, SLOT_ON_AIR, SLOT_BUSY} slot_state_e;

        logic [SIZE_W-1:0] size_reg [NUM_SLOTS];
        slot_state_e       state_q [NUM_SLOTS];
        logic [ID_W-1:0]   msg_id [NUM_SLOTS];
        logic [FRAG_W-1:0] frags_left [NUM_SLOTS];
        int unsigned       fill [NUM_SLOTS];
        logic [7:0]        buffer [NUM_SLOTS][MAX_MSG_BYTES];
        out_item_t         slot_reports [$];
        int unsigned       faults;

        function new();
            foreach (size_reg[i])
            begin
                size_reg[i]   = SIZE_RESET;
                state_q[i]    = SLOT_READY;
                msg_id[i]     = '0;
                frags_left[i] = '0;
                fill[i]       = 0;
            end
            faults = 0;
        endfunction

        function void write_size(int idx, logic [SIZE_W-1:0] value);
            size_reg[idx] = value;
        endfunction

        // Clamp the configured size to the buffer depth
        function int unsigned capacity(int s);
            return (size_reg[s] > MAX_MSG_BYTES) ? MAX_MSG_BYTES : size_reg[s];
        endfunction

        function logic [FRAG_W-1:0] first_frag(int s);
            int unsigned cap;
            cap = capacity(s);
            return (cap > FRAME_BYTES) ? FRAG_W'((cap - 1) / FRAME_BYTES) : '0;
        endfunction

        function void post(logic [EV_W-1:0] ev, int s, logic [DATA_W-1:0] word,
                           int unsigned nbytes, bit last);
            out_item_t r;
            r.event_res  = ev;
            r.out_slot   = SLOT_W'(s);
            r.message_id = msg_id[s];
            r.data_word  = word;
            r.word_bytes = LEN_W'(nbytes);
            r.last       = last;
            slot_reports.push_back(r);
        endfunction

        // Advance the slot state for one accepted item and queue its results
        function void note_frame(in_item_t it);
            int s;
            int unsigned cap, len, nwords, cnt, pos;
            logic [DATA_W-1:0] word;
            s = it.slot;
            if (it.opcode == OP_RELEASE)
            begin
                if (state_q[s] == SLOT_BUSY)
                    state_q[s] = SLOT_READY;
                post(EV_RELEASED, s, '0, 0, 1'b1);
                return;
            end
            if (state_q[s] == SLOT_BUSY)
            begin
                post(EV_DROPPED, s, '0, 0, 1'b1);
                return;
            end
            cap = capacity(s);
            // Arm a ready slot on any frame
            if (state_q[s] == SLOT_READY)
            begin
                state_q[s]    = SLOT_ON_AIR;
                fill[s]       = 0;
                msg_id[s]     = it.frame_ident[22:7];
                frags_left[s] = first_frag(s);
            end
            if (it.frame_ident[14:7] != msg_id[s][7:0])
            begin
                post(EV_IGNORED, s, '0, 0, 1'b1);
                return;
            end
            if (it.frame_ident[6:0] != frags_left[s])
            begin
                state_q[s] = SLOT_READY;
                post(EV_RESEQ, s, '0, 0, 1'b1);
                return;
            end
            // Append payload bytes, drop those past the slot size
            len = (it.frame_len > FRAME_BYTES) ? FRAME_BYTES : it.frame_len;
            for (int i = 0; i < len; i++)
            begin
                if (fill[s] < cap)
                begin
                    buffer[s][fill[s]] = it.frame_payload[8*i +: 8];
                    fill[s]++;
                end
            end
            if (frags_left[s] > 0)
            begin
                frags_left[s]--;
                post(EV_STORED, s, '0, 0, 1'b1);
                return;
            end
            // Last fragment: go busy and read out the message in words
            state_q[s] = SLOT_BUSY;
            nwords = (fill[s] + 7) / 8;
            if (nwords > MAX_RESULTS)
                nwords = MAX_RESULTS;
            if (nwords == 0)
            begin
                post(EV_COMPLETE, s, '0, 0, 1'b1);
                return;
            end
            for (int w = 0; w < nwords; w++)
            begin
                word = '0;
                cnt  = 0;
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    pos = w * FRAME_BYTES + i;
                    if (pos < fill[s])
                    begin
                        word[8*i +: 8] = buffer[s][pos];
                        cnt++;
                    end
                end
                post(EV_COMPLETE, s, word, cnt, w + 1 == nwords);
            end
        endfunction

        function void flag(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            faults++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        endfunction

        // Compare one result item with the oldest queued one
        function void check_result(out_item_t got);
            out_item_t want;
            if (slot_reports.size() == 0)
            begin
                faults++;
                $display("%0t: result with nothing queued, expected none got %h",
                         $time, got);
                return;
            end
            want = slot_reports.pop_front();
            if (got.event_res !== want.event_res)
                flag("event_res", want.event_res, got.event_res);
            if (got.out_slot !== want.out_slot)
                flag("out_slot", want.out_slot, got.out_slot);
            if (got.message_id !== want.message_id)
                flag("message_id", want.message_id, got.message_id);
            if (got.data_word !== want.data_word)
                flag("data_word", want.data_word, got.data_word);
            if (got.word_bytes !== want.word_bytes)
                flag("word_bytes", want.word_bytes, got.word_bytes);
            if (got.last !== want.last)
                flag("last", want.last, got.last);
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 frame_valid  = 1'b0;
    logic                 frame_stall;
    in_item_t             frame        = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    out_item_t            result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [SIZE_W-1:0]    cfg_data     = '0;

    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    reassembly_scoreboard sb = new();

    can_fragment_reassembler_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check each result item taken from the block
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // Stall the result side in short random bursts, or once for a long stretch
    initial
    begin
        int stall_len;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_len = LONG_HOLD;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
                stall_len = $urandom_range(1, 5);
            else
                stall_len = 0;
            result_stall <= (stall_len != 0);
            repeat ((stall_len != 0) ? stall_len : 1) @(negedge clk);
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t build(logic op, logic [SLOT_W-1:0] s,
                                       logic [IDENT_W-1:0] ident, logic [LEN_W-1:0] len,
                                       logic [DATA_W-1:0] payload);
        in_item_t it;
        it.opcode        = op;
        it.slot          = s;
        it.frame_ident   = ident;
        it.frame_len     = len;
        it.frame_payload = payload;
        return it;
    endfunction

    // Next item for a slot: the frame its sequence wants, or noise
    function automatic in_item_t make_item(int s, bit clean);
        in_item_t          it;
        logic [ID_W-1:0]   id;
        logic [FRAG_W-1:0] frag;
        it = build(OP_FRAME, SLOT_W'(s), IDENT_W'($urandom),
                   ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 15)) : LEN_W'(8),
                   rand_word());
        id   = ID_W'($urandom);
        frag = sb.first_frag(s);
        if (sb.state_q[s] == reassembly_scoreboard::SLOT_ON_AIR)
        begin
            id   = sb.msg_id[s];
            frag = sb.frags_left[s];
        end
        else if (sb.state_q[s] == reassembly_scoreboard::SLOT_BUSY &&
                 (clean || $urandom_range(0, 1) == 0))
            it.opcode = OP_RELEASE;
        it.frame_ident[22:7] = id;
        it.frame_ident[6:0]  = frag;
        if (!clean)
        begin
            case ($urandom_range(0, 3))
                0: it.frame_ident = IDENT_W'($urandom);
                1: it.frame_ident[14:7] = it.frame_ident[14:7] ^ 8'($urandom_range(1, 255));
                2: it.frame_ident[6:0] = FRAG_W'($urandom);
                default: it.opcode = OP_RELEASE;
            endcase
        end
        return it;
    endfunction

    // Offer one item after an optional gap, hold it until taken
    task automatic send_item(in_item_t it);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            frame_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        frame_valid <= 1'b1;
        frame       <= it;
        do @(posedge clk); while (frame_stall);
        sb.note_frame(it);
    endtask

    // Drop valid and wait until every queued result has come out
    task automatic settle();
        @(negedge clk);
        frame_valid <= 1'b0;
        while (sb.slot_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_sizes(logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
                             logic [SIZE_W-1:0] s2, logic [SIZE_W-1:0] s3);
        logic [SIZE_W-1:0] sizes [NUM_CFG];
        sizes = '{s0, s1, s2, s3};
        settle();
        for (int i = 0; i < NUM_CFG; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= sizes[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_size(i, sizes[i]);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_item(make_item($urandom_range(0, NUM_SLOTS - 1), $urandom_range(0, 99) >= 15));
    endtask

    initial
    begin
        // Hold reset, then release on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Single-frame cases at the reset size of eight bytes
        send_item(build(OP_RELEASE, 0, '0, 0, '0));
        send_item(build(OP_FRAME, 0, {6'h00, 16'h1234, 7'd0}, 8, '1));
        send_item(build(OP_FRAME, 0, '1, 15, '0));
        send_item(build(OP_RELEASE, 0, '0, 0, '0));
        send_item(build(OP_FRAME, 1, {6'h15, 16'hABCD, 7'd5}, 8, rand_word()));
        send_item(build(OP_FRAME, 1, {6'h2A, 16'h5555, 7'd0}, 15, rand_word()));
        send_item(build(OP_FRAME, 2, {6'h00, 16'h0000, 7'd0}, 0, rand_word()));
        send_item(build(OP_FRAME, 3, '1, 8, rand_word()));
        send_item(build(OP_FRAME, 3, {6'h3F, 16'hFFFF, 7'd0}, 3, rand_word()));
        for (int s = 1; s < NUM_SLOTS; s++)
            send_item(build(OP_RELEASE, SLOT_W'(s), '0, 0, '0));

        // Multi-frame cases: other source, truncation, partial last word
        set_sizes(1, 9, 16, 24);
        send_item(build(OP_FRAME, 1, {6'h01, 16'h0A5C, 7'd1}, 8, rand_word()));
        send_item(build(OP_FRAME, 1, {6'h01, 16'h0A77, 7'd0}, 8, rand_word()));
        send_item(build(OP_FRAME, 1, {6'h01, 16'h0A5C, 7'd0}, 8, rand_word()));
        send_item(build(OP_FRAME, 0, {6'h22, 16'h0101, 7'd0}, 8, rand_word()));
        send_item(build(OP_FRAME, 2, {6'h00, 16'h7E11, 7'd1}, 4, rand_word()));
        send_item(build(OP_FRAME, 2, {6'h00, 16'h7E11, 7'd0}, 8, rand_word()));
        send_item(build(OP_FRAME, 3, {6'h10, 16'h3C3C, 7'd2}, 8, rand_word()));
        send_item(build(OP_FRAME, 3, {6'h10, 16'h3C3C, 7'd2}, 8, rand_word()));
        for (int s = 0; s < 3; s++)
            send_item(build(OP_RELEASE, SLOT_W'(s), '0, 0, '0));
        run_random(72);

        // Extremes: empty slot, full buffer, oversized setting
        set_sizes(0, 256, 511, 17);
        for (int i = 0; i < 36; i++)
            send_item(make_item(1, 1'b1));
        run_random(72);

        set_sizes(SIZE_W'($urandom_range(1, 40)), SIZE_W'($urandom_range(1, 40)),
                  SIZE_W'($urandom_range(1, 40)), SIZE_W'($urandom_range(1, 40)));
        run_random(72);

        // Hold off the result side long enough to back up the frame side
        set_sizes(8, 33, 2, 64);
        hold_request = 1'b1;
        run_random(72);

        // Run the tail with no idling on either side
        set_sizes(SIZE_W'($urandom_range(1, 24)), SIZE_W'($urandom_range(1, 24)),
                  SIZE_W'($urandom_range(1, 24)), SIZE_W'($urandom_range(1, 24)));
        quiet = 1'b1;
        run_random(72);

        settle();
        if (sb.faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/cfr_pkg.sv
rtl/cfr_ctrl.sv
rtl/cfr_datapath.sv
rtl/can_fragment_reassembler_unit.sv
tb/can_fragment_reassembler_unit_tb.sv
